// ===== rtl/core/modbus_wind_register_reader_defines.svh =====
// assertion macros shared by the wind register reader rtl
`ifndef MODBUS_WIND_REGISTER_READER_DEFINES_SVH
`define MODBUS_WIND_REGISTER_READER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MWR_ASSERT_SAME(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define MWR_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mwr_pkg.sv =====
// types, constants and helper functions of the wind register reader
package mwr_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_SPEED_OFFSET   = 2'd1,
    CFG_ANGLE_OFFSET   = 2'd2
  } cfg_reg_t;

  // request kinds on the input channel
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_BYTE  = 1'b1
  } in_kind_t;

  // result kinds on the output channel
  typedef enum logic [1:0] {
    OUT_TX_BYTE = 2'd0,
    OUT_READING = 2'd1,
    OUT_FAILED  = 2'd2
  } out_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ADDR  = 3'd1,
    ST_BAD_FUNC  = 3'd2,
    ST_BAD_COUNT = 3'd3,
    ST_BAD_CRC   = 3'd4
  } status_t;

  // protocol constants
  localparam logic [15:0] CRC_SEED          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  REG_COUNT         = 8'h04;
  localparam logic [7:0]  REPLY_BYTE_COUNT  = 8'h08;

  // request frame byte positions
  localparam logic [2:0] REQ_ADDR     = 3'd0;
  localparam logic [2:0] REQ_FUNC     = 3'd1;
  localparam logic [2:0] REQ_COUNT_LO = 3'd5;
  localparam logic [2:0] REQ_CRC_LO   = 3'd6;
  localparam logic [2:0] REQ_CRC_HI   = 3'd7;

  // reply frame byte positions
  localparam logic [3:0] RX_ADDR      = 4'd0;
  localparam logic [3:0] RX_FUNC      = 4'd1;
  localparam logic [3:0] RX_COUNT     = 4'd2;
  localparam logic [3:0] RX_FIRST_REG = 4'd3;
  localparam logic [3:0] RX_SPEED_LO  = 4'd4;
  localparam logic [3:0] RX_LEVEL_LO  = 4'd6;
  localparam logic [3:0] RX_ANGLE_LO  = 4'd10;
  localparam logic [3:0] RX_CRC_LO    = 4'd11;
  localparam logic [3:0] RX_CRC_HI    = 4'd12;

  // angle and direction arithmetic in tenths
  localparam int FULL_TURN        = 3600;
  localparam int ANGLE_BIAS       = 7200;
  localparam int RAW_TURNS        = 65535 / FULL_TURN;
  localparam int MAX_BIASED_TURNS = 4;
  localparam int DIR_ROUND        = 225;
  localparam int DIR_RECIP        = 37283;  // ceil(2^24 / 450), exact for numerators < 2^15
  localparam int DIR_SHIFT        = 24;

  // one result item
  typedef struct packed {
    out_kind_t          out_kind;
    logic [7:0]         tx_byte;
    logic               last_of_run;
    status_t            status;
    logic signed [17:0] wind_speed_tenths;
    logic [15:0]        wind_level;
    logic [11:0]        wind_angle_tenths;
    logic [3:0]         direction_code;
  } result_t;

  // request transmitter to output path
  typedef struct packed {
    logic    active;
    logic    push;
    result_t res;
  } tx_out_t;

  // reply parser to output path
  typedef struct packed {
    logic    push;
    result_t res;
  } prs_out_t;

  // crc16 of one byte, reflected, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // raw 16-bit angle reduced into one turn by parallel threshold compares
  function automatic logic [11:0] mod_full_turn(input logic [15:0] raw);
    logic [15:0] r;
    logic        hit;
    r   = raw;
    hit = 1'b0;
    for (int j = RAW_TURNS; j >= 1; j--) begin
      if (!hit && raw >= 16'(j * FULL_TURN)) begin
        r   = raw - 16'(j * FULL_TURN);
        hit = 1'b1;
      end
    end
    return r[11:0];
  endfunction

endpackage

// ===== rtl/core/mwr_channels_if.sv =====
// valid/ready channel interfaces of the wind register reader

// input channel: start request or received byte
interface mwr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

// result channel: request byte or reading
interface mwr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_kind;
  logic [7:0]         tx_byte;
  logic               last_of_run;
  logic [2:0]         status;
  logic signed [17:0] wind_speed_tenths;
  logic [15:0]        wind_level;
  logic [11:0]        wind_angle_tenths;
  logic [3:0]         direction_code;

  modport source (
    output valid, output out_kind, output tx_byte, output last_of_run, output status,
    output wind_speed_tenths, output wind_level, output wind_angle_tenths,
    output direction_code, input ready
  );
  modport sink (
    input valid, input out_kind, input tx_byte, input last_of_run, input status,
    input wind_speed_tenths, input wind_level, input wind_angle_tenths,
    input direction_code, output ready
  );
endinterface

// ===== rtl/core/mwr_request_tx.sv =====
// request transmitter: sends the eight-byte read request, one byte per cycle while the output buffer has room
module mwr_request_tx import mwr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       can_push,
  input  logic [7:0] dev_addr,
  output tx_out_t    tx_out
);

  logic        active_r, active_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  cur_byte;
  logic        push;

  // byte at the current frame position
  always_comb begin
    case (idx_r)
      REQ_ADDR:     cur_byte = dev_addr;
      REQ_FUNC:     cur_byte = FUNC_READ_HOLDING;
      REQ_COUNT_LO: cur_byte = REG_COUNT;
      REQ_CRC_LO:   cur_byte = crc_r[7:0];
      REQ_CRC_HI:   cur_byte = crc_r[15:8];
      default:      cur_byte = 8'h00;
    endcase
  end

  assign push = active_r && can_push;

  // run counter and running crc over the header bytes
  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    if (start) begin
      active_nxt = 1'b1;
      idx_nxt    = REQ_ADDR;
      crc_nxt    = CRC_SEED;
    end else if (push) begin
      idx_nxt = idx_r + 3'd1;
      if (idx_r < REQ_CRC_LO) begin
        crc_nxt = crc_byte(crc_r, cur_byte);
      end
      if (idx_r == REQ_CRC_HI) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= REQ_ADDR;
      crc_r    <= CRC_SEED;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
    end
  end

  // result item for the byte being sent
  always_comb begin
    tx_out                 = '0;
    tx_out.active          = active_r;
    tx_out.push            = push;
    tx_out.res.out_kind    = OUT_TX_BYTE;
    tx_out.res.tx_byte     = cur_byte;
    tx_out.res.last_of_run = (idx_r == REQ_CRC_HI);
    tx_out.res.status      = ST_OK;
  end

endmodule

// ===== rtl/core/mwr_reply_parser.sv =====
// reply parser: checks the 13-byte reply and forms the reading or error status
module mwr_reply_parser import mwr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         dev_addr,
  input  logic signed [10:0] spd_off,
  input  logic signed [12:0] ang_off,
  output prs_out_t           prs_out
);

  logic [3:0]  pos_r, pos_nxt;
  logic        busy_r, busy_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic [15:0] level_r, level_nxt;
  logic [11:0] rmod_r, rmod_nxt;
  logic [17:0] last_speed_r, last_speed_nxt;
  logic [15:0] last_level_r, last_level_nxt;
  logic [11:0] last_angle_r, last_angle_nxt;
  logic [3:0]  last_dir_r, last_dir_nxt;

  logic [17:0] speed_sum;
  logic [14:0] ang_sum;
  logic [14:0] ang_red;
  logic        ang_hit;
  logic [14:0] dir_num;
  logic [30:0] dir_prod;
  logic [3:0]  dir_code;
  logic        fail;
  status_t     fail_code;

  // speed with signed offset
  assign speed_sum = {2'b00, speed_r} + {{7{spd_off[10]}}, spd_off};

  // angle: pre-reduced raw value plus offset plus two turns, always positive
  assign ang_sum = {3'b000, rmod_r} + {{2{ang_off[12]}}, ang_off} + 15'(ANGLE_BIAS);

  // reduce the biased angle into one turn
  always_comb begin
    ang_red = ang_sum;
    ang_hit = 1'b0;
    for (int k = MAX_BIASED_TURNS; k >= 1; k--) begin
      if (!ang_hit && ang_sum >= 15'(k * FULL_TURN)) begin
        ang_red = ang_sum - 15'(k * FULL_TURN);
        ang_hit = 1'b1;
      end
    end
  end

  // sector: a full turn is exactly 16 sectors, so the biased angle gives the same code
  assign dir_num  = {ang_sum[13:0], 1'b0} + 15'(DIR_ROUND);
  assign dir_prod = 31'(dir_num) * 31'(DIR_RECIP);
  assign dir_code = dir_prod[DIR_SHIFT+3:DIR_SHIFT];

  // header and crc checks
  always_comb begin
    fail      = 1'b0;
    fail_code = ST_OK;
    if (pos_r == RX_ADDR && rx_byte != dev_addr) begin
      fail      = 1'b1;
      fail_code = ST_BAD_ADDR;
    end else if (pos_r == RX_FUNC && rx_byte != FUNC_READ_HOLDING) begin
      fail      = 1'b1;
      fail_code = ST_BAD_FUNC;
    end else if (pos_r == RX_COUNT && rx_byte != REPLY_BYTE_COUNT) begin
      fail      = 1'b1;
      fail_code = ST_BAD_COUNT;
    end else if (pos_r == RX_CRC_HI && {rx_byte, held_r} != crc_r) begin
      fail      = 1'b1;
      fail_code = ST_BAD_CRC;
    end
  end

  // frame walk
  always_comb begin
    pos_nxt        = pos_r;
    busy_nxt       = busy_r;
    crc_nxt        = crc_r;
    held_nxt       = held_r;
    speed_nxt      = speed_r;
    level_nxt      = level_r;
    rmod_nxt       = rmod_r;
    last_speed_nxt = last_speed_r;
    last_level_nxt = last_level_r;
    last_angle_nxt = last_angle_r;
    last_dir_nxt   = last_dir_r;
    prs_out        = '0;
    if (start) begin
      busy_nxt = 1'b1;
      pos_nxt  = RX_ADDR;
      crc_nxt  = CRC_SEED;
    end else if (step && busy_r) begin
      if (fail) begin
        busy_nxt                      = 1'b0;
        pos_nxt                       = RX_ADDR;
        prs_out.push                  = 1'b1;
        prs_out.res.out_kind          = OUT_FAILED;
        prs_out.res.last_of_run       = 1'b1;
        prs_out.res.status            = fail_code;
        prs_out.res.wind_speed_tenths = last_speed_r;
        prs_out.res.wind_level        = last_level_r;
        prs_out.res.wind_angle_tenths = last_angle_r;
        prs_out.res.direction_code    = last_dir_r;
      end else if (pos_r <= RX_ANGLE_LO) begin
        crc_nxt = crc_byte(crc_r, rx_byte);
        if (pos_r >= RX_FIRST_REG && pos_r[0]) begin
          held_nxt = rx_byte;
        end else if (pos_r == RX_SPEED_LO) begin
          speed_nxt = {held_r, rx_byte};
        end else if (pos_r == RX_LEVEL_LO) begin
          level_nxt = {held_r, rx_byte};
        end else if (pos_r == RX_ANGLE_LO) begin
          rmod_nxt = mod_full_turn({held_r, rx_byte});
        end
        pos_nxt = pos_r + 4'd1;
      end else if (pos_r == RX_CRC_LO) begin
        held_nxt = rx_byte;
        pos_nxt  = RX_CRC_HI;
      end else begin
        last_speed_nxt                = speed_sum;
        last_level_nxt                = level_r;
        last_angle_nxt                = ang_red[11:0];
        last_dir_nxt                  = dir_code;
        busy_nxt                      = 1'b0;
        pos_nxt                       = RX_ADDR;
        prs_out.push                  = 1'b1;
        prs_out.res.out_kind          = OUT_READING;
        prs_out.res.last_of_run       = 1'b1;
        prs_out.res.status            = ST_OK;
        prs_out.res.wind_speed_tenths = speed_sum;
        prs_out.res.wind_level        = level_r;
        prs_out.res.wind_angle_tenths = ang_red[11:0];
        prs_out.res.direction_code    = dir_code;
      end
    end
  end

  // parser control and last good reading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= RX_ADDR;
      busy_r       <= 1'b0;
      crc_r        <= CRC_SEED;
      last_speed_r <= '0;
      last_level_r <= '0;
      last_angle_r <= '0;
      last_dir_r   <= '0;
    end else begin
      pos_r        <= pos_nxt;
      busy_r       <= busy_nxt;
      crc_r        <= crc_nxt;
      last_speed_r <= last_speed_nxt;
      last_level_r <= last_level_nxt;
      last_angle_r <= last_angle_nxt;
      last_dir_r   <= last_dir_nxt;
    end
  end

  // captured frame bytes
  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    speed_r <= speed_nxt;
    level_r <= level_nxt;
    rmod_r  <= rmod_nxt;
  end

endmodule

// ===== rtl/core/mwr_out_skid.sv =====
// two-entry output buffer that decouples the result channel from the core
module mwr_out_skid import mwr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  result_t   push_res,
  output logic      can_push,
  mwr_out_if.source out_chan
);

  result_t    ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       pop;
  result_t    head;

  assign head     = ent_r[rd_ptr_r];
  assign pop      = out_chan.valid && out_chan.ready;
  assign can_push = (count_r != 2'd2);

  // occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_res;
    end
  end

  // head entry drives the channel
  assign out_chan.valid             = (count_r != 2'd0);
  assign out_chan.out_kind          = head.out_kind;
  assign out_chan.tx_byte           = head.tx_byte;
  assign out_chan.last_of_run       = head.last_of_run;
  assign out_chan.status            = head.status;
  assign out_chan.wind_speed_tenths = head.wind_speed_tenths;
  assign out_chan.wind_level        = head.wind_level;
  assign out_chan.wind_angle_tenths = head.wind_angle_tenths;
  assign out_chan.direction_code    = head.direction_code;

endmodule

// ===== rtl/core/modbus_wind_register_reader.sv =====
// top level of the modbus rtu wind register reader
// Usage: in_chan carries requests; kind 0 starts a read of holding registers 0..3,
// kind 1 hands over one byte received from the sensor. out_chan returns results:
// eight request bytes to transmit (last_of_run on the eighth), or one reading or
// failure status when the reply ends. cfg_we/cfg_index/cfg_data write the slave
// address and the speed and angle offsets; write them only while no transfer runs.
// Path: a request reaches the input register on acceptance; the reading or
// failure of a final reply byte is then written into the output buffer before it
// is valid on out_chan; the first request byte of a start also passes the transmit run register.
// Throughput: one received byte per cycle while the output buffer has room and no request
// is being sent; a start holds the input while the eight request bytes go out, one per cycle with room.
// Reset: parser idle, last reading zero, address 1, offsets 0; the output is empty.
// Stall: a two-entry output buffer absorbs results; while it is full the core
// pauses and, once a byte waits in the input register, in_chan.ready drops; no result is lost or repeated.
`include "modbus_wind_register_reader_defines.svh"
module modbus_wind_register_reader import mwr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mwr_in_if.sink                in_chan,
  mwr_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]         dev_addr_r;
  logic signed [10:0] spd_off_r;
  logic signed [12:0] ang_off_r;
  logic               item_valid_r;
  in_kind_t           item_kind_r;
  logic [7:0]         item_byte_r;
  logic               consume;
  logic               start_req;
  logic               byte_req;
  logic               can_push;
  tx_out_t            tx_out;
  prs_out_t           prs_out;
  logic               res_push;
  result_t            res_sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd1;
      spd_off_r  <= '0;
      ang_off_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: dev_addr_r <= cfg_data[7:0];
        CFG_SPEED_OFFSET:   spd_off_r  <= cfg_data[10:0];
        CFG_ANGLE_OFFSET:   ang_off_r  <= cfg_data[12:0];
        default:            ;
      endcase
    end
  end

  // input register; a request leaves it once the core takes it
  assign consume = item_valid_r && !tx_out.active &&
                   (item_kind_r == KIND_START || can_push);
  assign in_chan.ready = !item_valid_r || consume;
  assign start_req     = consume && (item_kind_r == KIND_START);
  assign byte_req      = consume && (item_kind_r == KIND_BYTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_kind_r <= in_kind_t'(in_chan.kind);
      item_byte_r <= in_chan.rx_byte;
    end
  end

  mwr_request_tx u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_req),
    .can_push (can_push),
    .dev_addr (dev_addr_r),
    .tx_out   (tx_out)
  );

  mwr_reply_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_req),
    .step    (byte_req),
    .rx_byte (item_byte_r),
    .dev_addr(dev_addr_r),
    .spd_off (spd_off_r),
    .ang_off (ang_off_r),
    .prs_out (prs_out)
  );

  // result select: the transmitter owns the output while its run lasts
  assign res_push = tx_out.push || prs_out.push;
  assign res_sel  = tx_out.active ? tx_out.res : prs_out.res;

  mwr_out_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_res (res_sel),
    .can_push (can_push),
    .out_chan (out_chan)
  );

  // checks
  `MWR_ASSERT_NEXT(a_start_opens_run, clk, rst_n, start_req, tx_out.active, "start did not open a transmit run")
  `MWR_ASSERT_NEXT(a_run_closes, clk, rst_n, tx_out.push && tx_out.res.last_of_run, !tx_out.active, "transmit run overran its last byte")
  `MWR_ASSERT_SAME(a_single_writer, clk, rst_n, tx_out.push, !prs_out.push, "transmitter and parser wrote the buffer together")
  `MWR_ASSERT_SAME(a_push_has_room, clk, rst_n, res_push, can_push, "result written into a full output buffer")

endmodule
